// ----- src/lbp3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp3_pkg
// shared types, constants and the code function of the 3x3 lbp unit
// ----------------------------------------------------------------------------
package lbp3_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 12;
	localparam int ROW_W       = 12;
	localparam int COL_OUT_W   = 11;
	localparam int MIN_DIM     = 3;
	localparam int OUT_Q_DEPTH = 3;
	localparam int OUT_Q_CNT_W = $clog2(OUT_Q_DEPTH + 1);
	localparam int OUT_Q_PTR_W = $clog2(OUT_Q_DEPTH);

	// register map, selected by paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// neighbour offsets in comparison order (up-left used twice, up-right never)
	localparam int NB_ROW [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
	localparam int NB_COL [8] = '{-1, -1, -1, 0, 1, 1, -1, 0};

	// entry row*3 + col, row 0 = upper line, col 2 = newest
	typedef logic [8:0][PIX_W-1:0] window_t;

	typedef struct packed {
		logic [PIX_W-1:0]     code;
		logic [ROW_W-1:0]     center_row;
		logic [COL_OUT_W-1:0] center_col;
		logic                 frame_last;
	} result_t;

	function automatic logic [PIX_W-1:0] lbp_code(input window_t win);
		logic [PIX_W-1:0] acc;
		logic [3:0]       idx;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			idx = 4'((1 + NB_ROW[k]) * 3 + (1 + NB_COL[k]));
			if (win[idx] < win[4]) begin
				acc[3'(7 - k)] = 1'b1;
			end
		end
		return 8'd255 - acc;
	endfunction

endpackage

// ----- src/lbp3_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbp3_out_queue
// small result queue that decouples the pipeline from receiver stalls
// ----------------------------------------------------------------------------
module lbp3_out_queue import lbp3_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  result_t                push_word,
	output logic                   valid,
	input  logic                   ready,
	output result_t                word,
	output logic [OUT_Q_CNT_W-1:0] count
);

	result_t                entry_q [OUT_Q_DEPTH];
	logic [OUT_Q_PTR_W-1:0] wr_ptr_q;
	logic [OUT_Q_PTR_W-1:0] rd_ptr_q;
	logic [OUT_Q_CNT_W-1:0] count_q;
	logic                   pop;

	assign valid = (count_q != '0);
	assign pop   = valid && ready;
	assign word  = entry_q[rd_ptr_q];
	assign count = count_q;

	function automatic logic [OUT_Q_PTR_W-1:0] ptr_inc(input logic [OUT_Q_PTR_W-1:0] p);
		return (p == OUT_Q_PTR_W'(OUT_Q_DEPTH - 1)) ? '0 : p + OUT_Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + OUT_Q_CNT_W'(1);
				2'b01:   count_q <= count_q - OUT_Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/local_binary_pattern_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_unit
// 3x3 local binary pattern over a raster stream of 8-bit gray pixels
// ----------------------------------------------------------------------------
// usage:
//   input channel (pixel, frame_start) with in_valid / in_ready carries one
//   pixel word per handshake in raster order; frame_start puts that pixel at
//   row 0, col 0. output channel (code, center_row, center_col, frame_last)
//   with out_valid / out_ready carries one word per interior center pixel,
//   emitted once the pixel below-right of it has arrived. border pixels give
//   no output word. image_width / image_height sit on the apb port at 0x0
//   and 0x4 and are clamped to [3, MAX_LINE_PIXELS] and [3, 4095].
//   an accepted pixel is written back and coded in the cycle after its
//   acceptance; its word (if any) is then registered into the result queue
//   and offered on the output from there. throughput: one pixel per clock
//   while in_ready is high, set by the single read-modify-write of the line
//   memory per pixel; a pixel that hits the line entry still being written
//   back takes the forwarded word.
//   when the receiver stalls, up to three words are held in the result
//   queue; in_ready drops once queued words plus the word in flight fill it.
//   reset: position returns to row 0, col 0, window clears, registers go to
//   640 x 480, queue empties. line memory content is not cleared.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3_unit import lbp3_pkg::*; #(
	parameter int MAX_LINE_PIXELS = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// apb configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// pixel input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel,
	input  logic                 frame_start,
	// result output
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     code,
	output logic [ROW_W-1:0]     center_row,
	output logic [COL_OUT_W-1:0] center_col,
	output logic                 frame_last
);

	localparam int COL_W = $clog2(MAX_LINE_PIXELS);

	// configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] used_w;
	logic [CFG_W-1:0] used_h;
	logic             cfg_wr;

	// position of the next pixel
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] cur_col;
	logic [ROW_W-1:0] row_next;
	logic [COL_W-1:0] col_next;
	logic             col_wrap;
	logic             row_wrap;
	logic             emit_s0;
	logic             last_s0;
	logic             in_fire;

	// stage 1: line memory data back, write-back and window shift
	logic                 s1_v;
	logic [PIX_W-1:0]     px_s1;
	logic [COL_W-1:0]     addr_s1;
	logic                 emit_s1;
	logic                 last_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [COL_OUT_W-1:0] col_s1;
	logic [2*PIX_W-1:0]   rd_s1;
	logic                 fwd_s1;
	logic [2*PIX_W-1:0]   fwd_data_s1;
	logic [2*PIX_W-1:0]   line_s1;
	logic [2*PIX_W-1:0]   wdata_s1;

	// line memory: upper line in the high byte, middle line in the low byte
	logic [2*PIX_W-1:0] line_mem [MAX_LINE_PIXELS];

	window_t win_q;
	window_t win_next;

	// result queue
	logic                   push;
	result_t                push_word;
	result_t                q_word;
	logic [OUT_Q_CNT_W-1:0] q_count;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_q};
			REG_IMAGE_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_q};
		endcase
	end

	// clamped frame size actually used
	always_comb begin
		priority if (width_q < CFG_W'(MIN_DIM)) begin
			used_w = CFG_W'(MIN_DIM);
		end else if (32'(width_q) > MAX_LINE_PIXELS) begin
			used_w = CFG_W'(MAX_LINE_PIXELS);
		end else begin
			used_w = width_q;
		end
		used_h = (height_q < CFG_W'(MIN_DIM)) ? CFG_W'(MIN_DIM) : height_q;
	end

	// ------------------------------------------------------------------
	// stage 0: position tracking and line memory read
	// ------------------------------------------------------------------
	// the queue has room for every queued word plus the one in stage 1
	assign in_ready = ({1'b0, q_count} + {{OUT_Q_CNT_W{1'b0}}, s1_v})
		< (OUT_Q_CNT_W+1)'(OUT_Q_DEPTH);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cur_row  = frame_start ? '0 : row_q;
		cur_col  = frame_start ? '0 : col_q;
		// interior centre complete once its lower-right neighbour is here
		emit_s0  = (cur_row >= ROW_W'(2)) && (cur_row < used_h)
			&& (32'(cur_col) >= 32'd2) && (32'(cur_col) < 32'(used_w));
		last_s0  = (cur_row == used_h - CFG_W'(1))
			&& (32'(cur_col) == 32'(used_w) - 32'd1);
		col_wrap = (32'(cur_col) + 32'd1) >= 32'(used_w);
		row_wrap = ({1'b0, cur_row} + (ROW_W+1)'(1)) >= {1'b0, used_h};
		if (col_wrap) begin
			col_next = '0;
			row_next = row_wrap ? '0 : cur_row + ROW_W'(1);
		end else begin
			col_next = cur_col + COL_W'(1);
			// a row left beyond a shrunken height restarts the frame
			row_next = (cur_row >= used_h) ? '0 : cur_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			row_q <= row_next;
			col_q <= col_next;
		end
	end

	// ------------------------------------------------------------------
	// line memory: read at acceptance, write back in the next cycle
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_v) begin
			line_mem[addr_s1] <= wdata_s1;
		end
		if (in_fire) begin
			rd_s1 <= line_mem[cur_col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			s1_v   <= in_fire;
			// same entry read while the previous pixel writes it back
			fwd_s1 <= in_fire && s1_v && (cur_col == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wdata_s1;
		if (in_fire) begin
			px_s1   <= pixel;
			addr_s1 <= cur_col;
			emit_s1 <= emit_s0;
			last_s1 <= last_s0;
			row_s1  <= cur_row - ROW_W'(1);
			col_s1  <= COL_OUT_W'(32'(cur_col) - 32'd1);
		end
	end

	// ------------------------------------------------------------------
	// stage 1: column update, window shift and code
	// ------------------------------------------------------------------
	assign line_s1  = fwd_s1 ? fwd_data_s1 : rd_s1;
	// middle line moves up, new pixel becomes the middle line
	assign wdata_s1 = {line_s1[PIX_W-1:0], px_s1};

	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = line_s1[2*PIX_W-1:PIX_W];
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[5] = line_s1[PIX_W-1:0];
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_v) begin
			win_q <= win_next;
		end
	end

	assign push = s1_v && emit_s1;

	always_comb begin
		push_word.code       = lbp_code(win_next);
		push_word.center_row = row_s1;
		push_word.center_col = col_s1;
		push_word.frame_last = last_s1;
	end

	// ------------------------------------------------------------------
	// result queue and output
	// ------------------------------------------------------------------
	lbp3_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.valid     (out_valid),
		.ready     (out_ready),
		.word      (q_word),
		.count     (q_count)
	);

	assign code       = q_word.code;
	assign center_row = q_word.center_row;
	assign center_col = q_word.center_col;
	assign frame_last = q_word.frame_last;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// queued words plus the word in flight never exceed the queue
	a_queue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, q_count} + {{OUT_Q_CNT_W{1'b0}}, s1_v})
			<= (OUT_Q_CNT_W+1)'(OUT_Q_DEPTH))
		else $error("result queue overcommitted");

	// an accepted pixel always reaches the write-back stage next cycle
	a_fire_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_v)
		else $error("accepted pixel lost before write-back");

	// forwarding only follows a write-back in the previous cycle
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> $past(s1_v) && s1_v)
		else $error("forwarding without a pending write-back");

	// an emitted centre never lies on the top border row
	a_row_interior: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (row_s1 != '0))
		else $error("code pushed for a border row");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3x3 local binary pattern unit: pixel words go
// in through a valid/ready channel with bursty gaps, code words are taken out
// under a stall pattern and compared field by field with a cycle-free model
// of the window, the line stores and the raster position
// ----------------------------------------------------------------------------
module tb_top import lbp3_pkg::*; ();

	localparam int LINE_PIX     = 2048;
	localparam int SETTLE       = 8;     // cycles to let a word in flight come out
	localparam int HOLD_LEN     = 64;    // long receiver hold-off, in cycles
	localparam int RANDOM_ITEMS = 1000;
	localparam int PRINT_CAP    = 100;

	// grey levels around the usual comparison edges
	localparam logic [7:0] EDGE_VALS [9] = '{8'd0, 8'd1, 8'd2, 8'd127, 8'd128, 8'd129,
		8'd253, 8'd254, 8'd255};

	typedef enum int {STYLE_UNIFORM, STYLE_EDGES, STYLE_SMOOTH, STYLE_BINARY} pix_style_t;

	// one row of the hand-written probe frames; typed rows carry a known code
	typedef struct packed {
		logic [7:0] px;
		logic       fs;
		logic       typed;
		logic [7:0] code;
	} probe_row_t;

	// three 3x3 frames: each has a single interior centre at (1, 1)
	probe_row_t probe_tab [27] = '{
		// after reset, no frame start: only the up-right neighbour is dark, which
		// the comparison order never looks at
		'{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd128, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b1, 8'd255},
		// follows by row wrap alone: white centre, every neighbour black
		'{8'd0, 1'b0, 1'b0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0},
		'{8'd0, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0},
		'{8'd0, 1'b0, 1'b0, 8'd0}, '{8'd0, 1'b0, 1'b0, 8'd0},
		'{8'd0, 1'b0, 1'b1, 8'd0},
		// with frame start: only the up-left neighbour is dark, so two bits drop
		'{8'd0, 1'b1, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd128, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b0, 8'd0}, '{8'd255, 1'b0, 1'b0, 8'd0},
		'{8'd255, 1'b0, 1'b1, 8'd125}
	};

	// clock, reset and block inputs, all known from time zero
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 psel        = 1'b0;
	logic                 penable     = 1'b0;
	logic                 pwrite      = 1'b0;
	logic [2:0]           paddr       = '0;
	logic [31:0]          pwdata      = '0;
	logic                 in_valid    = 1'b0;
	logic [PIX_W-1:0]     pixel       = '0;
	logic                 frame_start = 1'b0;
	logic                 out_ready   = 1'b0;

	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_ready;
	logic                 out_valid;
	logic [PIX_W-1:0]     code;
	logic [ROW_W-1:0]     center_row;
	logic [COL_OUT_W-1:0] center_col;
	logic                 frame_last;

	// shadow of the configuration and of the block's pixel state
	logic [11:0] cfg_width  = 12'd640;
	logic [11:0] cfg_height = 12'd480;
	logic [7:0]  upper_line [LINE_PIX];
	logic [7:0]  middle_line [LINE_PIX];
	logic [7:0]  win [9];
	int unsigned row_pos = 0;
	int unsigned col_pos = 0;

	// code words still owed by the block, oldest first
	result_t pending_codes [$];

	// stimulus shaping
	bit         idle_on       = 1'b1;
	int         burst_left    = 0;
	int         hold_requests = 0;
	logic [7:0] walk_px       = 8'd128;

	// run statistics
	int n_errors     = 0;
	int n_items      = 0;
	int n_words      = 0;
	int n_frame_ends = 0;
	int n_settings   = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	local_binary_pattern_3x3_unit #(
		.MAX_LINE_PIXELS(LINE_PIX)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code       (code),
		.center_row (center_row),
		.center_col (center_col),
		.frame_last (frame_last)
	);

	initial begin : clear_model
		for (int i = 0; i < LINE_PIX; i++) begin
			upper_line[i]  = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) begin
			win[i] = '0;
		end
	end

	// ------------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------------

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= PRINT_CAP) begin
			$display("%0t: %s", $time, msg);
		end else if (n_errors == PRINT_CAP + 1) begin
			$display("%0t: further mismatches not shown", $time);
		end
	endtask

	// width the block actually works with after clamping
	function automatic int unsigned used_width(input logic [11:0] v);
		if (v < 12'd3) begin
			return 3;
		end
		if (v > LINE_PIX) begin
			return LINE_PIX;
		end
		return v;
	endfunction

	// advance the shadow by one pixel; returns 1 with the code word when the
	// pixel completes the neighbourhood of an interior centre
	function automatic bit lbp_predict(input logic [7:0] px, input logic fs,
		output result_t word);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned slot;
		logic [7:0]  up;
		logic [7:0]  mid;
		logic [7:0]  ctr;
		logic [7:0]  hits;
		bit          emit;
		w = used_width(cfg_width);
		h = (cfg_height < 12'd3) ? 3 : cfg_height;
		if (fs) begin
			row_pos = 0;
			col_pos = 0;
		end
		r    = row_pos;
		c    = col_pos;
		slot = c % LINE_PIX;

		// line stores roll down by one line at this column
		up                = upper_line[slot];
		mid               = middle_line[slot];
		upper_line[slot]  = mid;
		middle_line[slot] = px;

		// window slides left, newest column on the right
		win[0] = win[1];
		win[1] = win[2];
		win[2] = up;
		win[3] = win[4];
		win[4] = win[5];
		win[5] = mid;
		win[6] = win[7];
		win[7] = win[8];
		win[8] = px;

		emit = (r >= 2) && (r < h) && (c >= 2) && (c < w);
		word = '0;
		if (emit) begin
			ctr = win[4];
			// msb first: up-left, left, down-left, down, down-right, right,
			// up-left again, up; the up-right pixel plays no part
			hits = {win[0] < ctr, win[3] < ctr, win[6] < ctr, win[7] < ctr,
				win[8] < ctr, win[5] < ctr, win[0] < ctr, win[1] < ctr};
			word.code       = 8'd255 - hits;
			word.center_row = ROW_W'(r - 1);
			word.center_col = COL_OUT_W'(c - 1);
			word.frame_last = (r == h - 1) && (c == w - 1);
		end

		// raster advance; a position left outside by a smaller geometry wraps
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = (r >= h) ? 0 : r;
		end
		return emit;
	endfunction

	function automatic logic [7:0] gen_pixel(input pix_style_t style);
		case (style)
			STYLE_UNIFORM: begin
				return 8'($urandom_range(0, 255));
			end
			STYLE_EDGES: begin
				return EDGE_VALS[$urandom_range(0, 8)];
			end
			STYLE_SMOOTH: begin
				// slow random walk, so neighbours are often equal to the centre
				walk_px = walk_px + 8'($urandom_range(0, 4)) - 8'd2;
				return walk_px;
			end
			default: begin
				return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// apb access: setup cycle, access cycle, then the bus goes idle
	// ------------------------------------------------------------------------

	task automatic apb_write(input logic sel, input logic [11:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		// bits above the register are noise and must be dropped
		pwdata  <= {20'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (sel == REG_IMAGE_WIDTH) begin
			cfg_width = val;
		end else begin
			cfg_height = val;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic sel, output logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_regs();
		logic [31:0] rd;
		apb_read(REG_IMAGE_WIDTH, rd);
		if (rd[11:0] !== cfg_width) begin
			report($sformatf("image_width read back: expected %0d, got %0d",
				cfg_width, rd[11:0]));
		end
		apb_read(REG_IMAGE_HEIGHT, rd);
		if (rd[11:0] !== cfg_height) begin
			report($sformatf("image_height read back: expected %0d, got %0d",
				cfg_height, rd[11:0]));
		end
	endtask

	// ------------------------------------------------------------------------
	// pixel channel
	// ------------------------------------------------------------------------

	// stop offering, wait for every owed word, then let the pipe run empty
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_codes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// idles the block first; grew tells whether new columns come in
	task automatic set_geometry(input logic [11:0] w_reg, input logic [11:0] h_reg,
		output bit grew);
		settle();
		grew = used_width(w_reg) > used_width(cfg_width);
		apb_write(REG_IMAGE_WIDTH, w_reg);
		apb_write(REG_IMAGE_HEIGHT, h_reg);
		check_regs();
		n_settings++;
	endtask

	// offer one pixel word, hold it until taken, then book what it should cause
	task automatic send_item(input logic [7:0] px, input logic fs, input bit typed,
		input result_t typed_word);
		result_t word;
		bit      emit;
		int      gap;
		if (burst_left == 0) begin
			gap = idle_on ? int'($urandom_range(0, 12)) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid    <= 1'b1;
		pixel       <= px;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		emit = lbp_predict(px, fs, word);
		if (typed) begin
			pending_codes.push_back(typed_word);
		end else if (emit) begin
			pending_codes.push_back(word);
		end
		n_items++;
	endtask

	// ------------------------------------------------------------------------
	// code word receiver: checks every accepted word and drives out_ready
	// ------------------------------------------------------------------------
	initial begin : sink
		logic [15:0] ready_mask;
		int          mask_left;
		int          hold_left;
		int          holds_served;
		result_t     got;
		result_t     want;
		ready_mask   = '1;
		mask_left    = 0;
		hold_left    = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {code, center_row, center_col, frame_last};
				n_words++;
				if (got.frame_last === 1'b1) begin
					n_frame_ends++;
				end
				if (pending_codes.size() == 0) begin
					report($sformatf("word with nothing owed: expected none, got code %0d row %0d col %0d",
						got.code, got.center_row, got.center_col));
				end else begin
					want = pending_codes.pop_front();
					if (got.code !== want.code) begin
						report($sformatf("code at (%0d, %0d): expected %0d, got %0d",
							want.center_row, want.center_col, want.code, got.code));
					end
					if (got.center_row !== want.center_row) begin
						report($sformatf("center_row: expected %0d, got %0d",
							want.center_row, got.center_row));
					end
					if (got.center_col !== want.center_col) begin
						report($sformatf("center_col: expected %0d, got %0d",
							want.center_col, got.center_col));
					end
					if (got.frame_last !== want.frame_last) begin
						report($sformatf("frame_last at (%0d, %0d): expected %0d, got %0d",
							want.center_row, want.center_col, want.frame_last, got.frame_last));
					end
				end
			end

			// next ready: a requested long hold first, else the stall pattern
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else begin
				if (mask_left == 0) begin
					// new pattern from the 16-bit ready mask; never all stalls
					case ($urandom_range(0, 3))
						0:       ready_mask = '1;
						1:       ready_mask = 16'($urandom) | 16'h0001;
						2:       ready_mask = 16'($urandom | $urandom | $urandom) | 16'h0001;
						default: ready_mask = 16'($urandom & $urandom) | 16'h0001;
					endcase
					mask_left = 16;
				end
				out_ready <= ready_mask[0];
				ready_mask = {ready_mask[0], ready_mask[15:1]};
				mask_left--;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned len;
		logic [11:0] w_reg;
		logic [11:0] h_reg;
		bit          grew;
		logic        fs;
		int          phase_no;
		int          n_random;
		pix_style_t  style;
		result_t     tw;
		phase_no = 0;
		n_random = 0;

		// reset held low from time zero, released on a clock edge
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers must come up as 640 x 480
		check_regs();

		// probe frames at the smallest geometry; the first pixel after reset
		// carries no frame start and the second frame follows by wrap alone
		set_geometry(12'd3, 12'd3, grew);
		for (int i = 0; i < 27; i++) begin
			tw = {probe_tab[i].code, 12'd1, 11'd1, 1'b1};
			send_item(probe_tab[i].px, probe_tab[i].fs, probe_tab[i].typed, tw);
		end

		// random phases; geometry changes land mid-frame most of the time
		while (n_random < RANDOM_ITEMS) begin
			phase_no++;
			case ($urandom_range(0, 19))
				0:       w_reg = 12'($urandom_range(0, 2));   // clamps up to 3
				1:       w_reg = 12'd4095;                   // clamps down to the line size
				2, 3:    w_reg = 12'($urandom_range(13, 40));
				default: w_reg = 12'($urandom_range(3, 12));
			endcase
			case ($urandom_range(0, 19))
				0:       h_reg = 12'($urandom_range(0, 2));
				1:       h_reg = 12'd4095;
				2, 3:    h_reg = 12'($urandom_range(9, 20));
				default: h_reg = 12'($urandom_range(3, 8));
			endcase
			len = $urandom_range(20, 120);
			// second phase: dense codes and a long receiver hold-off, with the
			// sender offering back to back so the block has to push back
			if (phase_no == 2) begin
				w_reg = 12'd4;
				h_reg = 12'd200;
				len   = 120;
			end
			set_geometry(w_reg, h_reg, grew);
			idle_on = (phase_no == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			style   = pix_style_t'($urandom_range(0, 3));
			for (int unsigned i = 0; i < len; i++) begin
				if (phase_no == 2 && i == 8) begin
					hold_requests++;
				end
				// fourth phase: sender pauses halfway until all codes are in
				if (phase_no == 4 && i == len / 2) begin
					settle();
				end
				// a wider line would read columns never stored, so it must
				// start with a frame start
				if (i == 0) begin
					fs = grew || ($urandom_range(0, 1) == 1);
				end else begin
					fs = ($urandom_range(0, 99) == 0);
				end
				send_item(gen_pixel(style), fs, 1'b0, '0);
			end
			n_random += len;
		end

		settle();
		$display("run covered %0d pixel words over %0d geometry settings",
			n_items, n_settings);
		$display("%0d code words checked, %0d frame ends seen, %0d errors",
			n_words, n_frame_ends, n_errors);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin : watchdog
		#60_000_000;
		$display("timeout with %0d code words still owed", pending_codes.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- files.f -----
src/lbp3_pkg.sv
src/lbp3_out_queue.sv
src/local_binary_pattern_3x3_unit.sv
bench/tb_top.sv
